/* src/fss_pkg.sv */
// shared types, constants and codes for the framebuffer shape stamp block
package fss_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_RADIUS = 63;

    localparam int COORD_W = 8;
    localparam int DIM_W   = 9;
    localparam int RAD_W   = 6;
    localparam int CNT_W   = 14;
    localparam int COLOR_W = 24;
    localparam int ADDR_W  = 2 * COORD_W;
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int SC_W    = 11;

    // r/3 as (r * 171) >> 9, exact for every 6-bit radius
    localparam int DIV3_MUL   = 171;
    localparam int DIV3_SHIFT = 9;

    localparam logic [2:0] OP_WRITE    = 3'd0;
    localparam logic [2:0] OP_READ     = 3'd1;
    localparam logic [2:0] OP_CIRCLE   = 3'd2;
    localparam logic [2:0] OP_RECT     = 3'd3;
    localparam logic [2:0] OP_SQUARE   = 3'd4;
    localparam logic [2:0] OP_TRIANGLE = 3'd5;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [RAD_W-1:0]   radius;
        logic [7:0]         red_in;
        logic [7:0]         green_in;
        logic [7:0]         blue_in;
    } cmd_t;

    typedef struct packed {
        logic [7:0]       red_out;
        logic [7:0]       green_out;
        logic [7:0]       blue_out;
        logic [CNT_W-1:0] pixels_written;
        logic             status;
    } rsp_t;

    typedef struct packed {
        logic               start;
        logic [2:0]         shape;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [RAD_W-1:0]   radius;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
    } walk_req_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } walk_wr_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] count;
    } walk_st_t;

endpackage

/* src/fss_ram.sv */
// generic single-write, single-read ram with registered read data
module fss_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/fss_walk.sv */
// shape walker: scans the clipped bounding box, one pixel test per cycle in a row
module fss_walk (
    input  logic                clk,
    input  logic                rst_n,
    input  fss_pkg::walk_req_t  req,
    output fss_pkg::walk_wr_t   wr,
    output fss_pkg::walk_st_t   st
);

    localparam logic [2:0] W_IDLE  = 3'd0;
    localparam logic [2:0] W_SETUP = 3'd1;
    localparam logic [2:0] W_FIRST = 3'd2;
    localparam logic [2:0] W_ROW   = 3'd3;
    localparam logic [2:0] W_RUN   = 3'd4;
    localparam logic [2:0] W_DONE  = 3'd5;

    localparam int SC = fss_pkg::SC_W;
    localparam int CW = fss_pkg::COORD_W;

    logic [2:0] state_reg, state_next;
    logic [2:0] shape_reg;
    logic [CW-1:0] row_reg, col_reg;
    logic [fss_pkg::RAD_W-1:0] r_reg;
    logic [fss_pkg::DIM_W-1:0] w_reg, h_reg;
    logic [fss_pkg::RAD_W-1:0] dr_reg;
    logic [fss_pkg::RAD_W:0] dc_reg;
    logic [2*fss_pkg::RAD_W-1:0] rr_reg;
    logic [CW-1:0] i_reg, i_next, ilast_reg, j_reg, j_next, jhi_reg;
    logic [fss_pkg::CNT_W-1:0] cnt_reg;

    logic [14:0] div3_prod;
    logic signed [SC-1:0] row_s, col_s, i_s, j_s;
    logic signed [SC-1:0] lo_s, hi_s, hmax_s, wmax_s;
    logic signed [SC-1:0] k_s, span_s, jlo_s, jhi_s;
    logic signed [SC-1:0] y_s, x_s;
    logic [CW-1:0] ay, ax;
    logic [2*CW:0] sq_sum;
    logic covered;
    logic run_row_end;

    assign row_s  = SC'($signed({1'b0, row_reg}));
    assign col_s  = SC'($signed({1'b0, col_reg}));
    assign i_s    = SC'($signed({1'b0, i_reg}));
    assign j_s    = SC'($signed({1'b0, j_reg}));
    assign hmax_s = SC'($signed({1'b0, h_reg})) - SC'(1);
    assign wmax_s = SC'($signed({1'b0, w_reg})) - SC'(1);

    // rectangle row half-span: r/3 by reciprocal
    assign div3_prod = 15'(r_reg) * 15'(fss_pkg::DIV3_MUL);

    // row bounds
    assign lo_s = row_s - SC'($signed({1'b0, dr_reg}));
    assign hi_s = row_s + SC'($signed({1'b0, dr_reg}));

    // column bounds; triangle taper counted from the unclipped top row
    assign k_s    = i_s - row_s + SC'($signed({1'b0, r_reg}));
    assign span_s = (shape_reg == fss_pkg::OP_TRIANGLE) ? (k_s >>> 1)
                                                        : SC'($signed({1'b0, dc_reg}));
    assign jlo_s  = col_s - span_s;
    assign jhi_s  = col_s + span_s;

    // distance unit for circles: y*y + x*x against r*r
    assign y_s = row_s - i_s;
    assign x_s = col_s - j_s;
    assign ay  = (y_s < 0) ? CW'(-y_s) : CW'(y_s);
    assign ax  = (x_s < 0) ? CW'(-x_s) : CW'(x_s);
    assign sq_sum = (2*CW+1)'(ay * ay) + (2*CW+1)'(ax * ax);
    assign covered = (shape_reg != fss_pkg::OP_CIRCLE) || (sq_sum <= (2*CW+1)'(rr_reg));

    assign run_row_end = (j_reg == jhi_reg);

    assign wr.en   = (state_reg == W_RUN) && covered;
    assign wr.addr = {i_reg, j_reg};
    assign st.done  = (state_reg == W_DONE);
    assign st.count = cnt_reg;

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        case (state_reg)
            W_IDLE:
            begin
                if (req.start)
                begin
                    state_next = W_SETUP;
                end
            end
            W_SETUP:
            begin
                state_next = W_FIRST;
            end
            W_FIRST:
            begin
                i_next     = (lo_s < 0) ? '0 : CW'(lo_s);
                state_next = W_ROW;
            end
            W_ROW:
            begin
                j_next     = (jlo_s < 0) ? '0 : CW'(jlo_s);
                state_next = W_RUN;
            end
            W_RUN:
            begin
                if (run_row_end)
                begin
                    if (i_reg == ilast_reg)
                    begin
                        state_next = W_DONE;
                    end
                    else
                    begin
                        i_next     = i_reg + CW'(1);
                        state_next = W_ROW;
                    end
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                end
            end
            W_DONE:
            begin
                state_next = W_IDLE;
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == W_IDLE && req.start)
            begin
                cnt_reg <= '0;
            end
            else if (wr.en)
            begin
                cnt_reg <= cnt_reg + fss_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
        j_reg <= j_next;
        if (state_reg == W_IDLE && req.start)
        begin
            shape_reg <= req.shape;
            row_reg   <= req.row;
            col_reg   <= req.col;
            r_reg     <= req.radius;
            w_reg     <= req.width;
            h_reg     <= req.height;
        end
        if (state_reg == W_SETUP)
        begin
            dr_reg <= (shape_reg == fss_pkg::OP_RECT)
                      ? div3_prod[fss_pkg::DIV3_SHIFT +: fss_pkg::RAD_W] : r_reg;
            dc_reg <= (shape_reg == fss_pkg::OP_RECT) ? {r_reg, 1'b0} : {1'b0, r_reg};
            rr_reg <= (2*fss_pkg::RAD_W)'(r_reg * r_reg);
        end
        if (state_reg == W_FIRST)
        begin
            ilast_reg <= (hi_s > hmax_s) ? CW'(hmax_s) : CW'(hi_s);
        end
        if (state_reg == W_ROW)
        begin
            jhi_reg <= (jhi_s > wmax_s) ? CW'(wmax_s) : CW'(jhi_s);
        end
    end

endmodule

/* src/framebuffer_shape_stamp.sv */
// top level: framebuffer with pixel access and clipped filled shape stamping
// An RGB framebuffer of 256 x 256 24-bit pixels with one command channel and one
// response channel. Each command word writes a pixel, reads a pixel, or stamps a
// circle, rectangle, square or triangle around a centre pixel in the colour that
// centre held before the stamp, clipped to the configured image size. Every command
// gives exactly one response word. Commands are taken one at a time: cmd_stall is
// high from acceptance until the response is loaded into the output register, which
// then waits for the consumer on its own. A shape's run grows with the rows and the
// rows*columns of its clipped bounding box, 127 x 127 for a full-size square or
// circle; this is set by the single framebuffer write port, which the walker
// feeds one pixel a cycle, with a setup step per row to load that row's
// column span. The framebuffer is not cleared
// at reset: pixels must be written before they are read or used as a stamp centre.
// Configuration writes (image width and height) are always taken and should only be
// issued while no command is in flight.
module framebuffer_shape_stamp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  fss_pkg::cmd_t                 cmd,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output fss_pkg::rsp_t                 rsp,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [fss_pkg::DIM_W-1:0]     cfg_data
);

    localparam logic [2:0] T_IDLE   = 3'd0;
    localparam logic [2:0] T_EXEC   = 3'd1;
    localparam logic [2:0] T_RDWAIT = 3'd2;
    localparam logic [2:0] T_WALK   = 3'd3;
    localparam logic [2:0] T_DONE   = 3'd4;

    localparam logic [fss_pkg::DIM_W-1:0] W_MAX = fss_pkg::DIM_W'(fss_pkg::MAX_WIDTH);
    localparam logic [fss_pkg::DIM_W-1:0] H_MAX = fss_pkg::DIM_W'(fss_pkg::MAX_HEIGHT);
    localparam logic [fss_pkg::RAD_W-1:0] R_MAX = fss_pkg::RAD_W'(fss_pkg::MAX_RADIUS);

    logic [2:0] state_reg, state_next;
    logic [fss_pkg::DIM_W-1:0] width_reg, height_reg;
    fss_pkg::cmd_t item_reg;
    logic [fss_pkg::COLOR_W-1:0] res_colour_reg, res_colour_next;
    logic [fss_pkg::CNT_W-1:0] res_count_reg, res_count_next;
    logic res_status_reg, res_status_next;
    logic rsp_valid_reg, rsp_valid_next;
    fss_pkg::rsp_t rsp_reg;

    logic [fss_pkg::DIM_W-1:0] w_eff, h_eff;
    logic [fss_pkg::RAD_W-1:0] r_eff;
    logic [fss_pkg::COLOR_W-1:0] item_colour;
    logic off_image;
    logic rsp_free;
    logic pix_wr, rd_en;
    logic [fss_pkg::COLOR_W-1:0] rd_data;
    logic ram_we;
    logic [fss_pkg::ADDR_W-1:0] ram_waddr;
    logic [fss_pkg::COLOR_W-1:0] ram_wdata;

    fss_pkg::walk_req_t walk_req;
    fss_pkg::walk_wr_t  walk_wr;
    fss_pkg::walk_st_t  walk_st;

    // config values saturate at the framebuffer size, the radius at MAX_RADIUS
    assign w_eff = (width_reg > W_MAX) ? W_MAX : width_reg;
    assign h_eff = (height_reg > H_MAX) ? H_MAX : height_reg;
    assign r_eff = (item_reg.radius > R_MAX) ? R_MAX : item_reg.radius;

    assign item_colour = {item_reg.red_in, item_reg.green_in, item_reg.blue_in};
    assign off_image = ({1'b0, item_reg.row} >= h_eff) || ({1'b0, item_reg.col} >= w_eff);

    assign cmd_stall = (state_reg != T_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    // walker request, start pulses once the centre colour is in hand
    assign walk_req.start  = (state_reg == T_RDWAIT) && (item_reg.opcode != fss_pkg::OP_READ);
    assign walk_req.shape  = item_reg.opcode;
    assign walk_req.row    = item_reg.row;
    assign walk_req.col    = item_reg.col;
    assign walk_req.radius = r_eff;
    assign walk_req.width  = w_eff;
    assign walk_req.height = h_eff;

    // framebuffer port muxing: single pixel write or walker stamp
    assign ram_we    = pix_wr || walk_wr.en;
    assign ram_waddr = walk_wr.en ? walk_wr.addr : {item_reg.row, item_reg.col};
    assign ram_wdata = walk_wr.en ? res_colour_reg : item_colour;

    always_comb
    begin
        state_next      = state_reg;
        res_colour_next = res_colour_reg;
        res_count_next  = res_count_reg;
        res_status_next = res_status_reg;
        pix_wr          = 1'b0;
        rd_en           = 1'b0;
        case (state_reg)
            T_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = T_EXEC;
                end
            end
            T_EXEC:
            begin
                res_colour_next = '0;
                res_count_next  = '0;
                res_status_next = 1'b0;
                state_next      = T_DONE;
                case (item_reg.opcode)
                    fss_pkg::OP_WRITE:
                    begin
                        if (off_image)
                        begin
                            res_status_next = 1'b1;
                        end
                        else
                        begin
                            pix_wr          = 1'b1;
                            res_colour_next = item_colour;
                            res_count_next  = fss_pkg::CNT_W'(1);
                        end
                    end
                    fss_pkg::OP_READ, fss_pkg::OP_CIRCLE, fss_pkg::OP_RECT,
                    fss_pkg::OP_SQUARE, fss_pkg::OP_TRIANGLE:
                    begin
                        if (off_image)
                        begin
                            res_status_next = 1'b1;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            state_next = T_RDWAIT;
                        end
                    end
                    default:
                    begin
                        // unused opcode: all-zero response
                        state_next = T_DONE;
                    end
                endcase
            end
            T_RDWAIT:
            begin
                res_colour_next = rd_data;
                state_next = (item_reg.opcode == fss_pkg::OP_READ) ? T_DONE : T_WALK;
            end
            T_WALK:
            begin
                if (walk_st.done)
                begin
                    res_count_next = walk_st.count;
                    state_next     = T_DONE;
                end
            end
            T_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    assign rsp_valid_next = (rsp_valid_reg && rsp_stall) || ((state_reg == T_DONE) && rsp_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            rsp_valid_reg <= 1'b0;
            width_reg     <= W_MAX;
            height_reg    <= H_MAX;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    fss_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                    fss_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                    default:             width_reg  <= width_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_colour_reg <= res_colour_next;
        res_count_reg  <= res_count_next;
        res_status_reg <= res_status_next;
        if (cmd_valid && !cmd_stall)
        begin
            item_reg <= cmd;
        end
        if ((state_reg == T_DONE) && rsp_free)
        begin
            rsp_reg.red_out        <= res_colour_reg[23:16];
            rsp_reg.green_out      <= res_colour_reg[15:8];
            rsp_reg.blue_out       <= res_colour_reg[7:0];
            rsp_reg.pixels_written <= res_count_reg;
            rsp_reg.status         <= res_status_reg;
        end
    end

    fss_ram #(
        .WIDTH (fss_pkg::COLOR_W),
        .DEPTH (fss_pkg::DEPTH)
    ) u_frame (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (rd_en),
        .rd_addr ({item_reg.row, item_reg.col}),
        .rd_data (rd_data)
    );

    fss_walk u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (walk_req),
        .wr    (walk_wr),
        .st    (walk_st)
    );

endmodule

/* verif/framebuffer_shape_stamp_tb.sv */
// testbench for the framebuffer shape stamp block: directed and random pixel and stamp traffic
module framebuffer_shape_stamp_tb;

    // opcodes with no meaning: the block must answer with an all-zero word
    localparam logic [2:0] OP_UNUSED_A = 3'd6;
    localparam logic [2:0] OP_UNUSED_B = 3'd7;

    // a full 127 x 127 stamp keeps both channels quiet until it is done
    localparam int QUIET_LIMIT   = 60000;
    // covers the longest single-pixel command with margin
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_GAP       = 30;
    localparam int MAX_PRINTS    = 40;
    localparam int PHASE_ITEMS   = 12;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cmd_valid = 1'b0;
    logic                      cmd_stall;
    fss_pkg::cmd_t             cmd_word  = '0;
    logic                      rsp_valid;
    logic                      rsp_stall = 1'b0;
    fss_pkg::rsp_t             rsp_word;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic                      cfg_index = fss_pkg::CFG_WIDTH;
    logic [fss_pkg::DIM_W-1:0] cfg_data  = '0;

    // shadow copy of the framebuffer and the image size registers
    logic [fss_pkg::COLOR_W-1:0] shadow_pixel [0:fss_pkg::DEPTH-1];
    bit                          shadow_written [0:fss_pkg::DEPTH-1];
    logic [fss_pkg::DIM_W-1:0]   shadow_w = 9'd256;
    logic [fss_pkg::DIM_W-1:0]   shadow_h = 9'd256;

    // response words still owed by the block, oldest first
    fss_pkg::rsp_t rsp_awaited [$];
    fss_pkg::rsp_t rsp_want;
    int   mismatch_count = 0;
    int   rsp_seen       = 0;
    int   quiet_cycles   = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;

    framebuffer_shape_stamp dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // register value as the block uses it: anything above the maximum saturates
    function automatic int eff_dim(input logic [fss_pkg::DIM_W-1:0] v, input int lim);
        return (v > lim) ? lim : int'(v);
    endfunction

    function automatic fss_pkg::cmd_t make_cmd(input logic [2:0] op, input int row,
                                               input int col, input int rad,
                                               input logic [fss_pkg::COLOR_W-1:0] colour);
        fss_pkg::cmd_t c;
        c.opcode   = op;
        c.row      = fss_pkg::COORD_W'(row);
        c.col      = fss_pkg::COORD_W'(col);
        c.radius   = fss_pkg::RAD_W'(rad);
        c.red_in   = colour[23:16];
        c.green_in = colour[15:8];
        c.blue_in  = colour[7:0];
        return c;
    endfunction

    // apply one command word to the shadow framebuffer and return the word the block owes
    function automatic fss_pkg::rsp_t fb_apply(input fss_pkg::cmd_t c);
        fss_pkg::rsp_t               res;
        int                          w, h, row, col, rad, dr, dc, i, j, jlo, jhi, half, dy, dx;
        int unsigned                 cnt;
        logic [fss_pkg::COLOR_W-1:0] colour;
        res = '0;
        cnt = 0;
        w   = eff_dim(shadow_w, fss_pkg::MAX_WIDTH);
        h   = eff_dim(shadow_h, fss_pkg::MAX_HEIGHT);
        row = c.row;
        col = c.col;
        rad = c.radius;
        if (rad > fss_pkg::MAX_RADIUS)
            rad = fss_pkg::MAX_RADIUS;
        // meaningless opcode: nothing happens, all fields zero
        if (c.opcode > fss_pkg::OP_TRIANGLE)
            return res;
        // centre outside the image: flagged, store untouched
        if (row >= h || col >= w)
        begin
            res.status = 1'b1;
            return res;
        end
        if (c.opcode == fss_pkg::OP_WRITE)
        begin
            colour = {c.red_in, c.green_in, c.blue_in};
            shadow_pixel[row * fss_pkg::MAX_WIDTH + col]   = colour;
            shadow_written[row * fss_pkg::MAX_WIDTH + col] = 1'b1;
            cnt = 1;
        end
        else if (c.opcode == fss_pkg::OP_READ)
        begin
            colour = shadow_pixel[row * fss_pkg::MAX_WIDTH + col];
        end
        else
        begin
            // stamp colour is what the centre held before the stamp
            colour = shadow_pixel[row * fss_pkg::MAX_WIDTH + col];
            dr = rad;
            dc = rad;
            if (c.opcode == fss_pkg::OP_RECT)
            begin
                dr = rad / 3;
                dc = rad * 2;
            end
            for (i = (row - dr < 0) ? 0 : row - dr; i <= ((row + dr > h - 1) ? h - 1 : row + dr);
                 i++)
            begin
                jlo = (col - dc < 0) ? 0 : col - dc;
                jhi = (col + dc > w - 1) ? w - 1 : col + dc;
                if (c.opcode == fss_pkg::OP_TRIANGLE)
                begin
                    // taper counted from the geometric top row, even when it is clipped away
                    half = (i - (row - rad)) / 2;
                    jlo  = (col - half < 0) ? 0 : col - half;
                    jhi  = (col + half > w - 1) ? w - 1 : col + half;
                end
                for (j = jlo; j <= jhi; j++)
                begin
                    if (c.opcode == fss_pkg::OP_CIRCLE)
                    begin
                        dy = row - i;
                        dx = col - j;
                        if (dy * dy + dx * dx > rad * rad)
                            continue;
                    end
                    shadow_pixel[i * fss_pkg::MAX_WIDTH + j]   = colour;
                    shadow_written[i * fss_pkg::MAX_WIDTH + j] = 1'b1;
                    cnt++;
                end
            end
        end
        res.red_out        = colour[23:16];
        res.green_out      = colour[15:8];
        res.blue_out       = colour[7:0];
        res.pixels_written = fss_pkg::CNT_W'(cnt);
        res.status         = 1'b0;
        return res;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [23:0] got,
                               input logic [23:0] want);
        if (got !== want)
            note_mismatch($sformatf("word %0d %s got %0h want %0h", rsp_seen, name, got, want));
    endtask

    // send one command word; valid stays high afterwards so back-to-back words never drop it
    task automatic send_cmd(input fss_pkg::cmd_t c);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        rsp_awaited.insert(rsp_awaited.size(), fb_apply(c));
    endtask

    // drop valid, wait for every owed word, then let the block settle
    task automatic wait_idle();
        cmd_valid <= 1'b0;
        while (rsp_awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // program both image size registers while the block is idle
    task automatic set_image(input logic [fss_pkg::DIM_W-1:0] w,
                             input logic [fss_pkg::DIM_W-1:0] h);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= fss_pkg::CFG_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow_w  = w;
        cfg_index <= fss_pkg::CFG_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow_h  = h;
        cfg_valid <= 1'b0;
    endtask

    // pixel writes and reads at the corners, full and empty colours, meaningless opcodes
    task automatic test_pixel_access();
        send_cmd(make_cmd(fss_pkg::OP_WRITE, 0, 0, 0, 24'hFFFFFF));
        send_cmd(make_cmd(fss_pkg::OP_WRITE, 255, 255, 63, 24'h000000));
        send_cmd(make_cmd(fss_pkg::OP_WRITE, 0, 255, 21, 24'hA55AC3));
        send_cmd(make_cmd(fss_pkg::OP_WRITE, 255, 0, 42, 24'h5AA53C));
        send_cmd(make_cmd(fss_pkg::OP_READ, 0, 0, 0, 24'h000000));
        send_cmd(make_cmd(fss_pkg::OP_READ, 255, 255, 63, 24'hFFFFFF));
        send_cmd(make_cmd(OP_UNUSED_A, 17, 200, 9, 24'h123456));
        send_cmd(make_cmd(OP_UNUSED_B, 255, 255, 63, 24'hFFFFFF));
    endtask

    // each shape at full size, at radius zero, and clipped against the image edges
    task automatic test_shape_stamps();
        send_cmd(make_cmd(fss_pkg::OP_WRITE, 128, 128, 0, 24'h2C71E8));
        send_cmd(make_cmd(fss_pkg::OP_SQUARE, 128, 128, 63, 24'h000000));
        send_cmd(make_cmd(fss_pkg::OP_CIRCLE, 128, 128, 63, 24'h000000));
        send_cmd(make_cmd(fss_pkg::OP_RECT, 128, 128, 63, 24'h000000));
        send_cmd(make_cmd(fss_pkg::OP_TRIANGLE, 128, 128, 63, 24'h000000));
        // radius zero covers the centre only
        send_cmd(make_cmd(fss_pkg::OP_CIRCLE, 0, 0, 0, 24'h000000));
        send_cmd(make_cmd(fss_pkg::OP_RECT, 255, 255, 0, 24'h000000));
        send_cmd(make_cmd(fss_pkg::OP_SQUARE, 0, 255, 0, 24'h000000));
        send_cmd(make_cmd(fss_pkg::OP_TRIANGLE, 255, 0, 0, 24'h000000));
        // triangle whose top rows fall above the image, clipped on the right as well
        send_cmd(make_cmd(fss_pkg::OP_WRITE, 3, 250, 0, 24'h0F0F0F));
        send_cmd(make_cmd(fss_pkg::OP_TRIANGLE, 3, 250, 12, 24'h000000));
        send_cmd(make_cmd(fss_pkg::OP_CIRCLE, 255, 255, 5, 24'h000000));
    endtask

    // small images, zero size, saturating sizes, centres outside the image
    task automatic test_image_limits();
        set_image(9'd100, 9'd50);
        send_cmd(make_cmd(fss_pkg::OP_WRITE, 49, 99, 0, 24'h6B21D4));
        send_cmd(make_cmd(fss_pkg::OP_READ, 10, 100, 0, 24'h000000));
        send_cmd(make_cmd(fss_pkg::OP_CIRCLE, 50, 0, 3, 24'h000000));
        send_cmd(make_cmd(fss_pkg::OP_SQUARE, 49, 99, 4, 24'h000000));
        // zero width, then zero height: everything lies outside
        set_image(9'd0, 9'd511);
        send_cmd(make_cmd(fss_pkg::OP_WRITE, 0, 0, 0, 24'hFFFFFF));
        set_image(9'd511, 9'd0);
        send_cmd(make_cmd(fss_pkg::OP_READ, 0, 0, 0, 24'h000000));
        // sizes above the maximum saturate
        set_image(9'd511, 9'd300);
        send_cmd(make_cmd(fss_pkg::OP_TRIANGLE, 255, 255, 8, 24'h000000));
        // single-pixel image
        set_image(9'd1, 9'd1);
        send_cmd(make_cmd(fss_pkg::OP_SQUARE, 0, 0, 5, 24'h000000));
        send_cmd(make_cmd(fss_pkg::OP_READ, 0, 1, 0, 24'h000000));
    endtask

    // random traffic in four idling phases, each under its own image size
    task automatic test_random_traffic();
        int            phase, k, wl, hl, pick;
        fss_pkg::cmd_t c;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    set_image(9'd256, 9'd256);
                end
                1:
                begin
                    send_idle_pct  = 70;
                    recv_stall_pct = 0;
                    set_image(fss_pkg::DIM_W'($urandom_range(16, 256)),
                              fss_pkg::DIM_W'($urandom_range(16, 256)));
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 70;
                    set_image(fss_pkg::DIM_W'($urandom_range(1, 511)),
                              fss_pkg::DIM_W'($urandom_range(1, 511)));
                end
                default:
                begin
                    send_idle_pct  = 38;
                    recv_stall_pct = 38;
                    set_image(9'd256, fss_pkg::DIM_W'($urandom_range(1, 256)));
                end
            endcase
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                wl   = eff_dim(shadow_w, fss_pkg::MAX_WIDTH);
                hl   = eff_dim(shadow_h, fss_pkg::MAX_HEIGHT);
                pick = $urandom_range(99);
                if (pick < 25)
                    c.opcode = fss_pkg::OP_WRITE;
                else if (pick < 45)
                    c.opcode = fss_pkg::OP_READ;
                else if (pick < 94)
                    c.opcode = 3'($urandom_range(fss_pkg::OP_CIRCLE, fss_pkg::OP_TRIANGLE));
                else
                    c.opcode = 3'($urandom_range(OP_UNUSED_A, OP_UNUSED_B));
                // mostly inside the image, now and then anywhere
                c.row = fss_pkg::COORD_W'((hl == 0 || $urandom_range(99) < 8) ?
                                          $urandom_range(255) : $urandom_range(hl - 1));
                c.col = fss_pkg::COORD_W'((wl == 0 || $urandom_range(99) < 8) ?
                                          $urandom_range(255) : $urandom_range(wl - 1));
                // small stamps keep the run short, a few reach full size
                pick = $urandom_range(99);
                c.radius   = fss_pkg::RAD_W'((pick < 75) ? $urandom_range(7) :
                                             (pick < 95) ? $urandom_range(24) :
                                             $urandom_range(fss_pkg::MAX_RADIUS));
                c.red_in   = 8'($urandom);
                c.green_in = 8'($urandom);
                c.blue_in  = 8'($urandom);
                // a read or stamp centre must hold a written pixel: write it first
                if (c.opcode != fss_pkg::OP_WRITE && c.opcode <= fss_pkg::OP_TRIANGLE
                    && c.row < hl && c.col < wl
                    && !shadow_written[c.row * fss_pkg::MAX_WIDTH + c.col])
                    send_cmd(make_cmd(fss_pkg::OP_WRITE, c.row, c.col, 0, 24'($urandom)));
                send_cmd(c);
            end
        end
    endtask

    // response side: random stall, each accepted word checked against the oldest owed word
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (rsp_awaited.size() == 0)
                note_mismatch($sformatf("word %0d arrived with nothing owed", rsp_seen));
            else
            begin
                rsp_want = rsp_awaited.pop_front();
                check_field("red_out", rsp_word.red_out, rsp_want.red_out);
                check_field("green_out", rsp_word.green_out, rsp_want.green_out);
                check_field("blue_out", rsp_word.blue_out, rsp_want.blue_out);
                check_field("pixels_written", rsp_word.pixels_written,
                            rsp_want.pixels_written);
                check_field("status", rsp_word.status, rsp_want.status);
            end
            rsp_seen++;
        end
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog: too long without any word moving on any channel ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[framebuffer_shape_stamp] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_pixel_access();
        test_shape_stamps();
        test_image_limits();
        test_random_traffic();
        wait_idle();
        if (mismatch_count == 0)
            $display("[framebuffer_shape_stamp] OK");
        else
            $display("[framebuffer_shape_stamp] ERROR");
        $finish;
    end

endmodule

/* files.f */
src/fss_pkg.sv
src/fss_ram.sv
src/fss_walk.sv
src/framebuffer_shape_stamp.sv
verif/framebuffer_shape_stamp_tb.sv
